// File: hw/rtl/adaptive_threshold_binarizer_assert.svh
// Assertion macros for the adaptive threshold binarizer.
// Depends on signals named clk and rst_n in the module that includes it.
`ifndef ADAPTIVE_THRESHOLD_BINARIZER_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_BINARIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/atb_pkg.sv
// Package for the adaptive threshold binarizer: pipeline stage map, register
// indices, reset values and the stage payload type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package atb_pkg;

  // Configuration register indices.
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW = 3'd2;
  localparam logic [2:0] REG_K      = 3'd3;
  localparam logic [2:0] REG_EPS    = 3'd4;

  // Register reset values.
  localparam logic [11:0] RST_WIDTH  = 12'd1280;
  localparam logic [11:0] RST_HEIGHT = 12'd960;
  localparam logic [7:0]  RST_WINDOW = 8'd15;
  localparam logic [15:0] RST_K      = 16'd983;
  localparam logic [15:0] RST_EPS    = 16'd7;

  // Saturation limits of the signed 32-bit results.
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Restoring divider depths: one quotient bit per stage.
  localparam int DIV1_STEPS = 42;
  localparam int DIV2_STEPS = 32;

  // Stage map.
  localparam int ST_WIN   = 0;
  localparam int ST_AREA  = 1;
  localparam int ST_DIV1  = 2;
  localparam int ST_MEAN  = ST_DIV1 + DIV1_STEPS;
  localparam int ST_TERMS = ST_MEAN + 1;
  localparam int ST_PREP  = ST_TERMS + 1;
  localparam int ST_OVF   = ST_PREP + 1;
  localparam int ST_DIV2  = ST_OVF + 1;
  localparam int ST_QSAT  = ST_DIV2 + DIV2_STEPS;
  localparam int ST_GAIN  = ST_QSAT + 1;
  localparam int ST_SPLIT = ST_GAIN + 1;
  localparam int ST_PP    = ST_SPLIT + 1;
  localparam int ST_MID   = ST_PP + 1;
  localparam int ST_SUM   = ST_MID + 1;
  localparam int ST_THR   = ST_SUM + 1;
  localparam int N_STAGES = ST_THR + 1;

  // Payload carried down the pipeline; each stage fills the fields it owns.
  typedef struct packed {
    logic [15:0]        pix;
    logic               empty;
    logic               neg;
    logic               dn_zero;
    logic               ovf;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic signed [42:0] s;
    logic [61:0]        num;
    logic [44:0]        den;
    logic [45:0]        rem;
    logic [41:0]        quo;
    logic signed [42:0] m;
    logic signed [44:0] dn;
    logic signed [45:0] nm;
    logic signed [31:0] q;
    logic signed [47:0] g;
    logic [41:0]        um;
    logic [47:0]        ug;
    logic [44:0]        pll;
    logic [44:0]        plh;
    logic [44:0]        phl;
    logic [44:0]        phh;
    logic [70:0]        mid;
    logic [89:0]        mag;
    logic signed [31:0] thr;
    logic               bin;
  } pipe_t;

  // One result item.
  typedef struct packed {
    logic               bin;
    logic signed [31:0] thr;
    logic               empty;
  } res_t;

  // One restoring division step: shift in the next dividend bit and
  // subtract the divisor when it fits.
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       r;
    logic [45:0] sh;
    r  = p;
    sh = {p.rem[44:0], p.num[61]};
    r.num = {p.num[60:0], 1'b0};
    if (sh >= {1'b0, p.den}) begin
      r.rem = sh - {1'b0, p.den};
      r.quo = {p.quo[40:0], 1'b1};
    end else begin
      r.rem = sh;
      r.quo = {p.quo[40:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/adaptive_threshold_binarizer.sv
// Top level of the adaptive threshold binarizer: window clipping, integral
// image mean, ratio and gain arithmetic in one stalling pipeline.
// Depends on atb_pkg and adaptive_threshold_binarizer_assert.svh.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | in_valid/in_ready, col, row, pixel, sums| in
//  result  | out_valid/out_ready, bit, threshold, flag| out
//  config  | cfg_we, cfg_index, cfg_wdata            | in
//
// One pixel is taken per clock while the skid register is empty; the depth is
// set by the two restoring dividers (42 and 32 quotient bits, one per stage).
// Reset is synchronous and resets only the valid bits and the configuration registers.
// The whole pipeline advances together while the skid register is empty, so
// inputs keep flowing while a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_threshold_binarizer_assert.svh"

module adaptive_threshold_binarizer
  import atb_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [10:0]        in_col,
  input  logic [10:0]        in_row,
  input  logic [15:0]        in_pixel,
  input  logic [39:0]        in_sum_top_left,
  input  logic [39:0]        in_sum_bottom_right,
  input  logic [39:0]        in_sum_top_right,
  input  logic [39:0]        in_sum_bottom_left,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_binary_out,
  output logic signed [31:0] out_threshold_out,
  output logic               out_empty_window
);

  // Configuration registers.
  logic [11:0]        width_r;
  logic [11:0]        height_r;
  logic [7:0]         window_r;
  logic signed [15:0] k_r;
  logic [15:0]        eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      window_r <= RST_WINDOW;
      k_r      <= RST_K;
      eps_r    <= RST_EPS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata[11:0];
        REG_HEIGHT: height_r <= cfg_wdata[11:0];
        REG_WINDOW: window_r <= cfg_wdata[7:0];
        REG_K:      k_r      <= cfg_wdata;
        REG_EPS:    eps_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline and output side registers.
  pipe_t                pipe_r   [N_STAGES];
  pipe_t                pipe_nxt [N_STAGES];
  logic [N_STAGES-1:0]  vld_r;
  logic                 en;
  logic                 out_v_r;
  logic                 skid_v_r;
  res_t                 out_d_r;
  res_t                 skid_d_r;
  res_t                 res_new;
  logic                 take;
  logic                 push;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // Window clipping and corner sum, straight from the input ports.
  logic [12:0]        wc;
  logic [12:0]        hc;
  logic signed [13:0] cx, cy, half, xmin, xmax, ymin, ymax, wm1, hm1;

  always_comb begin
    if (width_r == 12'd0) begin
      wc = 13'd1;
    end else if (int'(width_r) > MAX_WIDTH) begin
      wc = 13'(MAX_WIDTH);
    end else begin
      wc = {1'b0, width_r};
    end
    if (height_r == 12'd0) begin
      hc = 13'd1;
    end else if (int'(height_r) > MAX_HEIGHT) begin
      hc = 13'(MAX_HEIGHT);
    end else begin
      hc = {1'b0, height_r};
    end
    cx   = $signed({3'b000, in_col});
    cy   = $signed({3'b000, in_row});
    half = $signed({7'd0, window_r[7:1]});
    wm1  = $signed({1'b0, wc}) - 14'sd1;
    hm1  = $signed({1'b0, hc}) - 14'sd1;
    xmin = (cx - half < 14'sd0) ? 14'sd0 : cx - half;
    ymin = (cy - half < 14'sd0) ? 14'sd0 : cy - half;
    xmax = (cx + half > wm1) ? wm1 : cx + half;
    ymax = (cy + half > hm1) ? hm1 : cy + half;

    pipe_nxt[ST_WIN]     = '0;
    pipe_nxt[ST_WIN].pix = in_pixel;
    pipe_nxt[ST_WIN].dx  = xmax - xmin;
    pipe_nxt[ST_WIN].dy  = ymax - ymin;
    pipe_nxt[ST_WIN].s   = $signed({3'b000, in_sum_top_left})
                         + $signed({3'b000, in_sum_bottom_right})
                         - $signed({3'b000, in_sum_top_right})
                         - $signed({3'b000, in_sum_bottom_left});
  end

  // Per-stage arithmetic.
  for (genvar i = 1; i < N_STAGES; i++) begin : g_stage
    if (i == ST_AREA) begin : g_area
      // Window area and magnitudes for the mean division.
      logic signed [27:0] area;
      logic [42:0]        smag;
      always_comb begin
        area = pipe_r[i-1].dx * pipe_r[i-1].dy;
        smag = pipe_r[i-1].s[42] ? 43'(-pipe_r[i-1].s) : 43'(pipe_r[i-1].s);
        pipe_nxt[i]       = pipe_r[i-1];
        pipe_nxt[i].empty = (area == 28'sd0);
        pipe_nxt[i].neg   = pipe_r[i-1].s[42] ^ area[27];
        pipe_nxt[i].den   = {17'd0, (area[27] ? 28'(-area) : 28'(area))};
        pipe_nxt[i].num   = {smag[41:0], 20'd0};
        pipe_nxt[i].rem   = '0;
        pipe_nxt[i].quo   = '0;
      end
    end else if ((i >= ST_DIV1 && i < ST_MEAN) || (i >= ST_DIV2 && i < ST_QSAT)) begin : g_div
      // One quotient bit of either divider.
      always_comb begin
        pipe_nxt[i] = div_step(pipe_r[i-1]);
      end
    end else if (i == ST_MEAN) begin : g_mean
      // Apply the sign to the mean, truncated toward zero.
      logic signed [42:0] mq;
      always_comb begin
        mq = $signed({1'b0, pipe_r[i-1].quo});
        pipe_nxt[i]   = pipe_r[i-1];
        pipe_nxt[i].m = pipe_r[i-1].neg ? -mq : mq;
      end
    end else if (i == ST_TERMS) begin : g_terms
      // Dn = 1 + eps - delta and Nm = 1 + eps - 2*delta.
      logic signed [45:0] base;
      logic signed [45:0] mx;
      logic signed [45:0] px;
      always_comb begin
        base = 46'sd65536 + $signed({30'd0, eps_r});
        mx   = {{3{pipe_r[i-1].m[42]}}, pipe_r[i-1].m};
        px   = $signed({30'd0, pipe_r[i-1].pix});
        pipe_nxt[i]    = pipe_r[i-1];
        pipe_nxt[i].dn = 45'(base + mx - px);
        pipe_nxt[i].nm = base + (mx <<< 1) - (px <<< 1);
      end
    end else if (i == ST_PREP) begin : g_prep
      // Magnitudes for the ratio division; dividend is Nm scaled by 2^16.
      logic [45:0] nmag;
      logic [61:0] nfull;
      always_comb begin
        nmag  = pipe_r[i-1].nm[45] ? 46'(-pipe_r[i-1].nm) : 46'(pipe_r[i-1].nm);
        nfull = {nmag[45:0], 16'd0};
        pipe_nxt[i]         = pipe_r[i-1];
        pipe_nxt[i].neg     = pipe_r[i-1].dn[44] ^ pipe_r[i-1].nm[45];
        pipe_nxt[i].dn_zero = (pipe_r[i-1].dn == 45'sd0);
        pipe_nxt[i].den     = pipe_r[i-1].dn[44] ? 45'(-pipe_r[i-1].dn)
                                                 : 45'(pipe_r[i-1].dn);
        pipe_nxt[i].rem     = {16'd0, nfull[61:32]};
        pipe_nxt[i].num     = {nfull[31:0], 30'd0};
        pipe_nxt[i].quo     = '0;
      end
    end else if (i == ST_OVF) begin : g_ovf
      // The quotient needs more than 32 bits when the top part reaches Dn.
      always_comb begin
        pipe_nxt[i]     = pipe_r[i-1];
        pipe_nxt[i].ovf = (pipe_r[i-1].rem >= {1'b0, pipe_r[i-1].den});
      end
    end else if (i == ST_QSAT) begin : g_qsat
      // Signed, saturated ratio; a zero denominator gives the negative limit.
      logic big;
      always_comb begin
        big = pipe_r[i-1].ovf || pipe_r[i-1].quo[31];
        pipe_nxt[i] = pipe_r[i-1];
        if (pipe_r[i-1].dn_zero) begin
          pipe_nxt[i].q = Q_MIN;
        end else if (pipe_r[i-1].neg) begin
          pipe_nxt[i].q = big ? Q_MIN : -$signed({1'b0, pipe_r[i-1].quo[30:0]});
        end else begin
          pipe_nxt[i].q = big ? Q_MAX : $signed({1'b0, pipe_r[i-1].quo[30:0]});
        end
      end
    end else if (i == ST_GAIN) begin : g_gain
      // Gain in Q.30: one plus k times the ratio.
      logic signed [47:0] kq;
      always_comb begin
        kq = k_r * pipe_r[i-1].q;
        pipe_nxt[i]   = pipe_r[i-1];
        pipe_nxt[i].g = kq + 48'sd1073741824;
      end
    end else if (i == ST_SPLIT) begin : g_split
      // Sign and magnitudes of mean and gain for the product.
      always_comb begin
        pipe_nxt[i]     = pipe_r[i-1];
        pipe_nxt[i].neg = pipe_r[i-1].m[42] ^ pipe_r[i-1].g[47];
        pipe_nxt[i].um  = pipe_r[i-1].m[42] ? 42'(-pipe_r[i-1].m) : 42'(pipe_r[i-1].m);
        pipe_nxt[i].ug  = pipe_r[i-1].g[47] ? 48'(-pipe_r[i-1].g) : 48'(pipe_r[i-1].g);
      end
    end else if (i == ST_PP) begin : g_pp
      // Four 21 x 24 partial products.
      always_comb begin
        pipe_nxt[i]     = pipe_r[i-1];
        pipe_nxt[i].pll = pipe_r[i-1].um[20:0]  * pipe_r[i-1].ug[23:0];
        pipe_nxt[i].plh = pipe_r[i-1].um[20:0]  * pipe_r[i-1].ug[47:24];
        pipe_nxt[i].phl = pipe_r[i-1].um[41:21] * pipe_r[i-1].ug[23:0];
        pipe_nxt[i].phh = pipe_r[i-1].um[41:21] * pipe_r[i-1].ug[47:24];
      end
    end else if (i == ST_MID) begin : g_mid
      // Cross terms.
      always_comb begin
        pipe_nxt[i]     = pipe_r[i-1];
        pipe_nxt[i].mid = ({26'd0, pipe_r[i-1].plh} << 24)
                        + ({26'd0, pipe_r[i-1].phl} << 21);
      end
    end else if (i == ST_SUM) begin : g_sum
      // Full product magnitude.
      always_comb begin
        pipe_nxt[i]     = pipe_r[i-1];
        pipe_nxt[i].mag = {45'd0, pipe_r[i-1].pll} + {19'd0, pipe_r[i-1].mid}
                        + {pipe_r[i-1].phh, 45'd0};
      end
    end else begin : g_thr
      // Floor of the product over 2^30, saturated, and the pixel compare.
      logic [59:0]        vp;
      logic [60:0]        vn;
      logic signed [31:0] t;
      always_comb begin
        vp = pipe_r[i-1].mag[89:30];
        vn = {1'b0, vp} + {60'd0, |pipe_r[i-1].mag[29:0]};
        if (!pipe_r[i-1].neg) begin
          t = (vp > 60'h0_7FFF_FFFF) ? Q_MAX : $signed({1'b0, vp[30:0]});
        end else begin
          t = (vn >= 61'h0_8000_0000) ? Q_MIN : -$signed({1'b0, vn[30:0]});
        end
        pipe_nxt[i] = pipe_r[i-1];
        if (pipe_r[i-1].empty) begin
          pipe_nxt[i].thr = '0;
          pipe_nxt[i].bin = 1'b0;
        end else begin
          pipe_nxt[i].thr = t;
          pipe_nxt[i].bin = $signed({16'd0, pipe_r[i-1].pix}) > t;
        end
      end
    end
  end

  // Pipeline payload moves as one when enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N_STAGES; j++) begin
        pipe_r[j] <= pipe_nxt[j];
      end
    end
  end

  // Output register with a skid stage behind it.
  assign res_new = '{bin: pipe_r[N_STAGES-1].bin, thr: pipe_r[N_STAGES-1].thr,
                     empty: pipe_r[N_STAGES-1].empty};
  assign take = out_v_r && out_ready;
  assign push = en && vld_r[N_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[N_STAGES-2:0], in_valid};
      end
      if (skid_v_r) begin
        if (take) begin
          skid_v_r <= 1'b0;
        end
      end else if (push) begin
        if (out_v_r && !take) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_d_r <= res_new;
      end else begin
        out_d_r <= res_new;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_binary_out    = out_d_r.bin;
  assign out_threshold_out = out_d_r.thr;
  assign out_empty_window  = out_d_r.empty;

  // Checks on the output buffering and the empty window case.
  `ATB_ASSERT_SAME(a_skid_behind_out, skid_v_r, out_v_r, "skid holds a result with output empty")
  `ATB_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_r), "pipeline moved while stalled")
  `ATB_ASSERT_SAME(a_empty_zero, out_v_r && out_d_r.empty, !out_d_r.bin && out_d_r.thr == 32'sd0, "empty window result not cleared")

endmodule

`default_nettype wire

// File: verif/adaptive_threshold_binarizer_tb.sv
// Self-checking testbench for the adaptive threshold binarizer: directed table
// then random pixels, each checked against a typed result or an in-bench predictor.
// Depends on atb_pkg and the adaptive_threshold_binarizer RTL.
`timescale 1ns / 1ps

module adaptive_threshold_binarizer_tb;
  import atb_pkg::*;

  localparam int LATENCY     = 88;
  localparam int N_RANDOM    = 1030;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [10:0] col;
    logic [10:0] row;
    logic [15:0] pixel;
    logic [39:0] tl;
    logic [39:0] br;
    logic [39:0] tr;
    logic [39:0] bl;
  } pixel_item_t;

  typedef struct {
    pixel_item_t px;
    bit          typed;
    res_t        res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [10:0] in_col = '0;
  logic [10:0] in_row = '0;
  logic [15:0] in_pixel = '0;
  logic [39:0] in_sum_top_left = '0;
  logic [39:0] in_sum_bottom_right = '0;
  logic [39:0] in_sum_top_right = '0;
  logic [39:0] in_sum_bottom_left = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_binary_out;
  logic signed [31:0] out_threshold_out;
  logic out_empty_window;

  // Shadow copy of the configuration registers.
  logic [11:0] cur_width;
  logic [11:0] cur_height;
  logic [7:0]  cur_window;
  logic [15:0] cur_k;
  logic [15:0] cur_eps;

  res_t expected_thresholds[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   quiet_phase = 1'b0;
  bit   stall_enable = 1'b1;

  adaptive_threshold_binarizer DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_col(in_col), .in_row(in_row), .in_pixel(in_pixel),
    .in_sum_top_left(in_sum_top_left), .in_sum_bottom_right(in_sum_bottom_right),
    .in_sum_top_right(in_sum_top_right), .in_sum_bottom_left(in_sum_bottom_left),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_binary_out(out_binary_out), .out_threshold_out(out_threshold_out),
    .out_empty_window(out_empty_window)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("adaptive_threshold_binarizer_tb failed");
      $finish;
    end
  end

  // Signed divide truncating toward zero, on magnitudes.
  function automatic longint div_trunc(longint a, longint b);
    longint ua;
    longint ub;
    longint qm;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    qm = ua / ub;
    return ((a < 0) != (b < 0)) ? -qm : qm;
  endfunction

  // floor(m*g / 2^30), saturated to 32 bits, in 128-bit arithmetic.
  function automatic longint scaled_threshold(longint m, longint g);
    logic signed [127:0] prod;
    logic signed [127:0] fl;
    prod = 128'(signed'(m)) * 128'(signed'(g));
    fl = prod >>> 30;
    if (fl > 128'sd2147483647) return 64'sd2147483647;
    if (fl < -128'sd2147483648) return -64'sd2147483648;
    return longint'(fl);
  endfunction

  function automatic res_t predict_threshold(pixel_item_t px);
    longint w, h, half, c, r, p, s, k, eps;
    longint xmin, xmax, ymin, ymax, area, m, d, dn, nm, q, g, t;
    res_t res;
    w = (cur_width == 0) ? 1 : ((cur_width > 2048) ? 2048 : cur_width);
    h = (cur_height == 0) ? 1 : ((cur_height > 2048) ? 2048 : cur_height);
    half = cur_window / 2;
    c = px.col;
    r = px.row;
    p = px.pixel;
    s = longint'(px.tl) + longint'(px.br) - longint'(px.tr) - longint'(px.bl);
    k = longint'(signed'(cur_k));
    eps = cur_eps;
    xmin = (c - half < 0) ? 0 : c - half;
    ymin = (r - half < 0) ? 0 : r - half;
    xmax = (c + half > w - 1) ? w - 1 : c + half;
    ymax = (r + half > h - 1) ? h - 1 : r + half;
    area = (xmax - xmin) * (ymax - ymin);
    if (area == 0) begin
      res.bin = 1'b0;
      res.thr = '0;
      res.empty = 1'b1;
      return res;
    end
    m = div_trunc(s, area);
    d = p - m;
    dn = 65536 + eps - d;
    nm = dn - d;
    if (dn == 0) begin
      q = -64'sd2147483648;
    end else begin
      q = div_trunc(nm * 65536, dn);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
    end
    g = (64'sd1 << 30) + k * q;
    t = scaled_threshold(m, g);
    res.bin = (p > t);
    res.thr = 32'(t);
    res.empty = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Result side: random stalls and checking against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_thresholds.size() == 0) begin
        report_mismatch("unexpected result transfer, bin", out_binary_out, 0);
      end else begin
        if (out_binary_out !== expected_thresholds[0].bin)
          report_mismatch("binary_out", out_binary_out, expected_thresholds[0].bin);
        if (out_threshold_out !== expected_thresholds[0].thr)
          report_mismatch("threshold_out", out_threshold_out, expected_thresholds[0].thr);
        if (out_empty_window !== expected_thresholds[0].empty)
          report_mismatch("empty_window", out_empty_window, expected_thresholds[0].empty);
        void'(expected_thresholds.pop_front());
      end
    end
  end

  initial begin : ready_driver
    int n;
    @(posedge clk);
    while (1) begin
      if (!quiet_phase && stall_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  // One register write; the enable is dropped by the caller after the last write.
  task automatic write_register(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  cur_width = value[11:0];
      REG_HEIGHT: cur_height = value[11:0];
      REG_WINDOW: cur_window = value[7:0];
      REG_K:      cur_k = value;
      REG_EPS:    cur_eps = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] w, logic [15:0] h, logic [15:0] win,
                                logic [15:0] k, logic [15:0] eps);
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
    write_register(REG_WINDOW, win);
    write_register(REG_K, k);
    write_register(REG_EPS, eps);
    cfg_we <= 1'b0;
  endtask

  // Drives one pixel and holds it until the transfer; an optional sender gap first.
  task automatic send_pixel(pixel_item_t px, res_t want);
    int n;
    if (!quiet_phase && stall_enable && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col <= px.col;
    in_row <= px.row;
    in_pixel <= px.pixel;
    in_sum_top_left <= px.tl;
    in_sum_bottom_right <= px.br;
    in_sum_top_right <= px.tr;
    in_sum_bottom_left <= px.bl;
    do @(posedge clk); while (!in_ready);
    expected_thresholds.insert(expected_thresholds.size(), want);
  endtask

  // Waits for the pipeline to drain before a register write.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_thresholds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [39:0] rand_sum(int mode);
    case (mode)
      0: return '0;
      1: return 40'hFF_FFFF_FFFF;
      2: return 40'({$urandom_range(0, 255), $urandom()});
      default: return 40'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  // Plausible integral-image corners for a mean near a random level, or noise.
  function automatic pixel_item_t random_pixel(longint w, longint h);
    pixel_item_t px;
    longint base;
    longint spread;
    px.col = (w > 2 && $urandom_range(0, 9) != 0) ? 11'($urandom_range(0, w - 1))
                                                   : 11'($urandom());
    px.row = (h > 2 && $urandom_range(0, 9) != 0) ? 11'($urandom_range(0, h - 1))
                                                   : 11'($urandom());
    px.pixel = 16'($urandom());
    if ($urandom_range(0, 4) == 0) begin
      px.tl = rand_sum($urandom_range(0, 3));
      px.br = rand_sum($urandom_range(0, 3));
      px.tr = rand_sum($urandom_range(0, 3));
      px.bl = rand_sum($urandom_range(0, 3));
    end else begin
      base = {$urandom_range(0, 127), $urandom()};
      spread = longint'($urandom_range(0, 65535)) * $urandom_range(1, 4000);
      px.tl = 40'(base);
      px.tr = 40'(base + $urandom_range(0, 1 << 16));
      px.bl = 40'(base + $urandom_range(0, 1 << 16));
      px.br = 40'(longint'(px.tr) + longint'(px.bl) - base + spread);
    end
    return px;
  endfunction

  initial begin : stimulus
    table_row_t directed[$];
    table_row_t row_item;
    pixel_item_t px;
    res_t empty_res;
    res_t flat_res;
    int phase;
    int n;
    empty_res.bin = 1'b0;
    empty_res.thr = '0;
    empty_res.empty = 1'b1;
    flat_res.bin = 1'b0;
    flat_res.thr = '0;
    flat_res.empty = 1'b0;
    cur_width = RST_WIDTH;
    cur_height = RST_HEIGHT;
    cur_window = RST_WINDOW;
    cur_k = RST_K;
    cur_eps = RST_EPS;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, run with reset settings. Rows with zero sums and a dark
    // pixel give a zero mean, so a zero threshold and a clear bit are typed in.
    directed = '{
      '{'{11'd0, 11'd0, 16'd0, 40'd0, 40'd0, 40'd0, 40'd0}, 1'b1, flat_res},
      '{'{11'd100, 11'd100, 16'hFFFF, 40'd0, 40'hFF_FFFF_FFFF, 40'd0, 40'd0}, 1'b0, empty_res},
      '{'{11'd100, 11'd100, 16'd0, 40'hFF_FFFF_FFFF, 40'd0, 40'hFF_FFFF_FFFF,
          40'hFF_FFFF_FFFF}, 1'b0, empty_res},
      '{'{11'd2047, 11'd2047, 16'h8000, 40'd5, 40'd9, 40'd1, 40'd2}, 1'b0, empty_res},
      '{'{11'd1279, 11'd959, 16'h1234, 40'd1000, 40'd400000, 40'd9000, 40'd900},
          1'b0, empty_res},
      '{'{11'd640, 11'd480, 16'd32768, 40'd0, 40'd1835008, 40'd0, 40'd0}, 1'b0, empty_res},
      '{'{11'd7, 11'd7, 16'd1, 40'd0, 40'd6422528, 40'd0, 40'd0}, 1'b0, empty_res},
      '{'{11'd1300, 11'd5, 16'd65535, 40'd0, 40'd10000, 40'd0, 40'd0}, 1'b0, empty_res},
      '{'{11'd5, 11'd1000, 16'd300, 40'd0, 40'd10000, 40'd0, 40'd0}, 1'b0, empty_res},
      '{'{11'd1024, 11'd1024, 16'd0, 40'd0, 40'd0, 40'd0, 40'd0}, 1'b1, flat_res}
    };
    foreach (directed[i]) begin
      row_item = directed[i];
      send_pixel(row_item.px, row_item.typed ? row_item.res : predict_threshold(row_item.px));
    end
    drain_pipeline();

    // Degenerate image: one column gives an empty window everywhere in range.
    apply_settings(16'd1, 16'd2048, 16'd255, 16'h7FFF, 16'hFFFF);
    for (int i = 0; i < 4; i++) begin
      px = random_pixel(1, 2048);
      px.col = 11'(i);
      send_pixel(px, empty_res);
    end
    // Zero window: an empty window whatever the pixel.
    drain_pipeline();
    apply_settings(16'd2048, 16'd2048, 16'd1, 16'h8000, 16'd0);
    px = random_pixel(2048, 2048);
    send_pixel(px, empty_res);
    drain_pipeline();
    apply_settings(16'd64, 16'd64, 16'd8, 16'd983, 16'd0);
    // Zero stabilised denominator: a mean of minus one under a full-scale
    // pixel puts delta at exactly 1 + eps with eps zero.
    px = '{11'd30, 11'd30, 16'hFFFF, 40'd0, 40'd0, 40'd64, 40'd0};
    send_pixel(px, predict_threshold(px));
    px = '{11'd30, 11'd30, 16'hFFFF, 40'd0, 40'd0, 40'd0, 40'd0};
    send_pixel(px, predict_threshold(px));
    px = '{11'd30, 11'd30, 16'hFFFF, 40'd0, 40'd64 * 65535, 40'd0, 40'd0};
    send_pixel(px, predict_threshold(px));

    // Random phases, each under new settings, extremes among them.
    for (phase = 0; phase < 10; phase++) begin
      drain_pipeline();
      case (phase)
        0: apply_settings(16'd1280, 16'd960, 16'd15, 16'd983, 16'd7);
        1: apply_settings(16'hFFFF, 16'hFFFF, 16'd255, 16'h7FFF, 16'hFFFF);
        2: apply_settings(16'd0, 16'd0, 16'd0, 16'h8000, 16'd0);
        3: apply_settings(16'd2, 16'd2, 16'd3, 16'hC000, 16'd1);
        4: apply_settings(16'd4095, 16'd2049, 16'd254, 16'd0, 16'd65535);
        default: apply_settings(16'($urandom_range(1, 2048)), 16'($urandom_range(1, 2048)),
                                16'($urandom_range(0, 255)), 16'($urandom()),
                                16'($urandom()));
      endcase
      if (phase == 9) quiet_phase = 1'b1;
      stall_enable = (phase != 6);
      n = N_RANDOM / 10;
      for (int i = 0; i < n; i++) begin
        px = random_pixel((cur_width == 0) ? 1 : ((cur_width > 2048) ? 2048 : cur_width),
                          (cur_height == 0) ? 1 : ((cur_height > 2048) ? 2048 : cur_height));
        send_pixel(px, predict_threshold(px));
      end
    end
    in_valid <= 1'b0;

    while (expected_thresholds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("adaptive_threshold_binarizer_tb passed");
    else
      $display("adaptive_threshold_binarizer_tb failed");
    $finish;
  end

endmodule
